// File: hdl/cpa_pkg.sv
// Shared types and constants for the critical path analysis core.
// No dependencies.
package cpa_pkg;

  localparam int NODE_W    = 4;
  localparam int MAX_NODES = 16;
  localparam int EARLY_W   = 20;
  localparam int LATE_W    = 21;
  localparam int COUNT_W   = 5;
  localparam int RES_LIMIT = 48;

  localparam logic [EARLY_W-1:0] EARLY_MAX = 20'hFFFFF;
  localparam logic signed [LATE_W-1:0] LATE_MIN = -21'sd1048575;

  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 5'd16;

  // result kinds
  localparam logic [1:0] KIND_NODE  = 2'd0;
  localparam logic [1:0] KIND_CRIT  = 2'd1;
  localparam logic [1:0] KIND_CYCLE = 2'd2;

  // register indexes
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]                kind;
    logic [NODE_W-1:0]         node;
    logic [NODE_W-1:0]         head;
    logic [EARLY_W-1:0]        early;
    logic signed [LATE_W-1:0]  late;
  } result_t;

endpackage

// File: hdl/cpa_edge_mem.sv
// Edge store: one write port, one registered read port.
// Uses no package.
module cpa_edge_mem #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 24
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/critical_path_analysis_core.sv
// Critical path analysis core: loads edges, then sorts and times the graph.
// Edges are accepted only while idle. The analysis after the final edge walks the
// edge memory with a read state and a writeback state per edge read; output
// stalls can hold it. Node results can leave one per cycle while the output
// is not stalled; each critical edge result waits for the edge scan that finds it.
// Synchronous active-high reset clears control state and sets node_count to 16.
// Depends on cpa_pkg and cpa_edge_mem.
module critical_path_analysis_core #(
  parameter int MAX_EDGES   = 32,
  parameter int WEIGHT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // edge input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // edge_source, edge_target, edge_weight
  input  logic        s_tlast,   // edge_is_last
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // node_or_source, edge_head, earliest, latest, zero pad
  output logic [1:0]  m_tuser,   // result_kind
  output logic        m_tlast    // final_result
);

  localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CNT_W  = $clog2(MAX_EDGES + 1);
  localparam int DATA_W = 2 * cpa_pkg::NODE_W + WEIGHT_BITS;
  localparam int NW     = cpa_pkg::NODE_W;
  localparam int N      = cpa_pkg::MAX_NODES;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INIT     = 5'd1;
  localparam logic [4:0] S_DEG_RD   = 5'd2;
  localparam logic [4:0] S_DEG_WB   = 5'd3;
  localparam logic [4:0] S_MARK     = 5'd4;
  localparam logic [4:0] S_PICK     = 5'd5;
  localparam logic [4:0] S_FWD_RD   = 5'd6;
  localparam logic [4:0] S_FWD_WB   = 5'd7;
  localparam logic [4:0] S_CHECK    = 5'd8;
  localparam logic [4:0] S_BWD_SEL  = 5'd9;
  localparam logic [4:0] S_BWD_RD   = 5'd10;
  localparam logic [4:0] S_BWD_WB   = 5'd11;
  localparam logic [4:0] S_BWD_DONE = 5'd12;
  localparam logic [4:0] S_NODE     = 5'd13;
  localparam logic [4:0] S_CRIT_RD  = 5'd14;
  localparam logic [4:0] S_CRIT_WB  = 5'd15;
  localparam logic [4:0] S_FLUSH    = 5'd16;

  logic [4:0] state;
  logic [cpa_pkg::COUNT_W-1:0] node_count;
  logic [CNT_W-1:0] edges_loaded;
  logic [CNT_W-1:0] eidx;

  logic [CNT_W-1:0]                  indeg [N];
  logic [cpa_pkg::EARLY_W-1:0]       early [N];
  logic signed [cpa_pkg::LATE_W-1:0] late  [N];
  logic [NW-1:0]                     topo  [N];
  logic [N-1:0]                      ready_mask;

  logic [NW:0]   sorted;
  logic [NW:0]   bidx;
  logic [NW-1:0] cur;
  logic [NW-1:0] cv;
  logic [cpa_pkg::EARLY_W-1:0]       cur_early;
  logic signed [cpa_pkg::LATE_W-1:0] cur_late;
  logic [5:0] res_count;

  cpa_pkg::result_t pend;
  logic pend_valid;
  cpa_pkg::result_t out_res;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {27'd0, node_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= cpa_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == cpa_pkg::REG_NODE_COUNT) begin
      node_count <= pwdata[cpa_pkg::COUNT_W-1:0];
    end
  end

  // clamped node count
  logic [cpa_pkg::COUNT_W-1:0] nc;
  logic [NW-1:0] nlast;
  always_comb begin
    if (node_count == '0) begin
      nc = 5'd1;
    end else if (node_count > 5'(N)) begin
      nc = 5'(N);
    end else begin
      nc = node_count;
    end
    nlast = NW'(nc - 5'd1);
  end

  // edge memory
  logic [31:0]       w32;
  logic              mem_wr;
  logic              mem_rd;
  logic [DATA_W-1:0] mem_q;

  assign s_tready = (state == S_IDLE);
  assign w32 = {16'd0, s_tdata[23:8]};
  assign mem_wr = s_tvalid && s_tready && (edges_loaded < CNT_W'(MAX_EDGES));
  assign mem_rd = (state == S_DEG_RD) || (state == S_FWD_RD) ||
                  (state == S_BWD_RD) || (state == S_CRIT_RD);

  cpa_edge_mem #(
    .DEPTH (MAX_EDGES),
    .ADDR_W(ADDR_W),
    .DATA_W(DATA_W)
  ) u_edges (
    .clk    (clk),
    .wr_en  (mem_wr),
    .wr_addr(edges_loaded[ADDR_W-1:0]),
    .wr_data({w32[WEIGHT_BITS-1:0], s_tdata[7:4], s_tdata[3:0]}),
    .rd_en  (mem_rd),
    .rd_addr(eidx[ADDR_W-1:0]),
    .rd_data(mem_q)
  );

  logic [NW-1:0]          e_tail;
  logic [NW-1:0]          e_head;
  logic [WEIGHT_BITS-1:0] e_dur;
  logic                   e_ok;
  logic                   edges_done;
  assign e_tail = mem_q[NW-1:0];
  assign e_head = mem_q[2*NW-1:NW];
  assign e_dur  = mem_q[DATA_W-1:2*NW];
  assign e_ok   = ({1'b0, e_tail} < nc) && ({1'b0, e_head} < nc);
  assign edges_done = (eidx == edges_loaded);

  // forward time: saturate at the earliest-time limit
  logic [33:0] fwd_sum;
  logic [cpa_pkg::EARLY_W-1:0] fwd_t;
  assign fwd_sum = {14'd0, cur_early} + 34'(e_dur);
  assign fwd_t = (fwd_sum > 34'(cpa_pkg::EARLY_MAX)) ? cpa_pkg::EARLY_MAX
                                                     : fwd_sum[cpa_pkg::EARLY_W-1:0];

  // backward time: late of the head less duration, clamped below
  logic signed [34:0] bwd_sum;
  logic signed [cpa_pkg::LATE_W-1:0] bwd_t;
  logic signed [cpa_pkg::LATE_W-1:0] late_head;
  assign late_head = late[e_head];
  assign bwd_sum = 35'(late_head) - $signed({1'b0, 34'(e_dur)});
  assign bwd_t = (bwd_sum < 35'(cpa_pkg::LATE_MIN)) ? cpa_pkg::LATE_MIN
                                                    : bwd_sum[cpa_pkg::LATE_W-1:0];

  // lowest ready node
  logic [NW-1:0] pick;
  logic          pick_found;
  always_comb begin
    pick = '0;
    pick_found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (ready_mask[i]) begin
        pick = NW'(i);
        pick_found = 1'b1;
      end
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  logic crit_hit;
  assign crit_hit = e_ok && e_tail == cur && e_head == cv &&
                    bwd_sum == $signed({15'd0, early[cur]}) &&
                    res_count < 6'(cpa_pkg::RES_LIMIT);

  logic can_push;
  assign can_push = !pend_valid || out_free;

  // move the held result to the output register
  logic move_out;
  assign move_out = pend_valid && out_free &&
                    ((state == S_FLUSH) || (state == S_NODE) ||
                     (state == S_CRIT_WB && crit_hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      edges_loaded <= '0;
      eidx         <= '0;
      pend_valid   <= 1'b0;
      m_tvalid     <= 1'b0;
      ready_mask   <= '0;
      sorted       <= '0;
      bidx         <= '0;
      res_count    <= '0;
    end else begin
      if (move_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (mem_wr) begin
              edges_loaded <= edges_loaded + 1'b1;
            end
            if (s_tlast) begin
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          for (int i = 0; i < N; i++) begin
            indeg[i] <= '0;
            early[i] <= '0;
          end
          ready_mask <= '0;
          sorted     <= '0;
          res_count  <= '0;
          eidx       <= '0;
          state      <= S_DEG_RD;
        end
        S_DEG_RD: begin
          state <= edges_done ? S_MARK : S_DEG_WB;
        end
        S_DEG_WB: begin
          if (e_ok) begin
            indeg[e_head] <= indeg[e_head] + 1'b1;
          end
          eidx  <= eidx + 1'b1;
          state <= S_DEG_RD;
        end
        S_MARK: begin
          for (int i = 0; i < N; i++) begin
            ready_mask[i] <= (5'(i) < nc) && (indeg[i] == '0);
          end
          state <= S_PICK;
        end
        S_PICK: begin
          if (pick_found) begin
            ready_mask[pick] <= 1'b0;
            topo[sorted[NW-1:0]] <= pick;
            sorted    <= sorted + 1'b1;
            cur       <= pick;
            cur_early <= early[pick];
            eidx      <= '0;
            state     <= S_FWD_RD;
          end else begin
            state <= S_CHECK;
          end
        end
        S_FWD_RD: begin
          state <= edges_done ? S_PICK : S_FWD_WB;
        end
        S_FWD_WB: begin
          if (e_ok && e_tail == cur) begin
            if (indeg[e_head] != '0) begin
              indeg[e_head] <= indeg[e_head] - 1'b1;
              if (indeg[e_head] == CNT_W'(1)) begin
                ready_mask[e_head] <= 1'b1;
              end
            end
            if (fwd_t > early[e_head]) begin
              early[e_head] <= fwd_t;
            end
          end
          eidx  <= eidx + 1'b1;
          state <= S_FWD_RD;
        end
        S_CHECK: begin
          if (sorted < nc) begin
            pend       <= '{kind: cpa_pkg::KIND_CYCLE, node: '0, head: '0,
                            early: '0, late: '0};
            pend_valid <= 1'b1;
            state      <= S_FLUSH;
          end else begin
            for (int i = 0; i < N; i++) begin
              late[i] <= $signed({1'b0, early[nlast]});
            end
            bidx  <= nc;
            state <= S_BWD_SEL;
          end
        end
        S_BWD_SEL: begin
          if (bidx == '0) begin
            bidx  <= '0;
            state <= S_NODE;
          end else begin
            cur      <= topo[NW'(bidx - 1'b1)];
            cur_late <= late[topo[NW'(bidx - 1'b1)]];
            eidx     <= '0;
            state    <= S_BWD_RD;
          end
        end
        S_BWD_RD: begin
          state <= edges_done ? S_BWD_DONE : S_BWD_WB;
        end
        S_BWD_WB: begin
          if (e_ok && e_tail == cur && bwd_t < cur_late) begin
            cur_late <= bwd_t;
          end
          eidx  <= eidx + 1'b1;
          state <= S_BWD_RD;
        end
        S_BWD_DONE: begin
          late[cur] <= cur_late;
          bidx      <= bidx - 1'b1;
          state     <= S_BWD_SEL;
        end
        S_NODE: begin
          if (can_push) begin
            pend <= '{kind: cpa_pkg::KIND_NODE, node: topo[bidx[NW-1:0]], head: '0,
                      early: early[topo[bidx[NW-1:0]]], late: late[topo[bidx[NW-1:0]]]};
            pend_valid <= 1'b1;
            res_count  <= res_count + 6'd1;
            if (bidx == {1'b0, nlast}) begin
              cur   <= '0;
              cv    <= '0;
              eidx  <= '0;
              state <= S_CRIT_RD;
            end else begin
              bidx <= bidx + 1'b1;
            end
          end
        end
        S_CRIT_RD: begin
          if (edges_done) begin
            eidx <= '0;
            if (cv == nlast) begin
              cv <= '0;
              if (cur == nlast) begin
                state <= S_FLUSH;
              end else begin
                cur <= cur + 1'b1;
              end
            end else begin
              cv <= cv + 1'b1;
            end
          end else begin
            state <= S_CRIT_WB;
          end
        end
        S_CRIT_WB: begin
          if (!crit_hit) begin
            eidx  <= eidx + 1'b1;
            state <= S_CRIT_RD;
          end else if (can_push) begin
            pend <= '{kind: cpa_pkg::KIND_CRIT, node: cur, head: cv,
                      early: early[cur], late: bwd_t};
            pend_valid <= 1'b1;
            res_count  <= res_count + 6'd1;
            eidx       <= eidx + 1'b1;
            state      <= S_CRIT_RD;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_valid   <= 1'b0;
            edges_loaded <= '0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output payload follows the held result
  always_ff @(posedge clk) begin
    if (!rst && move_out) begin
      out_res <= pend;
      m_tlast <= (state == S_FLUSH);
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {7'd0, out_res.late, out_res.early, out_res.head, out_res.node};

endmodule
